// ===== design/class_debounce_weight_tracker_core_assert.svh =====
// Assertion macros for the class debounce weight tracker.
// Used by the top level; needs a clock and a synchronous active-high reset.
`ifndef CLASS_DEBOUNCE_WEIGHT_TRACKER_CORE_ASSERT_SVH
`define CLASS_DEBOUNCE_WEIGHT_TRACKER_CORE_ASSERT_SVH

// same-cycle implication
`define CDWT_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("cdwt assertion failed");

// next-cycle implication
`define CDWT_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("cdwt assertion failed");

`endif

// ===== design/cdwt_pkg.sv =====
// Shared types and constants of the class debounce weight tracker.
// No dependencies; imported by the cell, the output buffer and the top level.
`default_nettype none

package cdwt_pkg;

  localparam int WEIGHT_W = 16;
  localparam int CLASS_W  = 3;
  localparam int CONF_W   = 8;
  localparam int SHIFT_W  = 4;
  localparam int RUN_W    = 16;

  localparam logic [CLASS_W-1:0] RAW_TRUSTED_LO = 3'd2;
  localparam logic [CLASS_W-1:0] RAW_TRUSTED_HI = 3'd3;
  localparam logic [CLASS_W-1:0] RAW_INVALID    = 3'd7;
  localparam logic [CLASS_W-1:0] CLASS_NONE     = 3'd0;
  localparam logic [CONF_W-1:0]  CONFIRM_MAX    = 8'd255;

  localparam logic                MODEL_SUPPORTED_RST = 1'b1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_SCALE_RST    = 16'd1024;
  localparam logic [SHIFT_W-1:0]  WEIGHT_SHIFT_RST    = 4'd3;
  localparam logic [RUN_W-1:0]    DEBOUNCE_TICKS_RST  = 16'd2;

  typedef enum logic [1:0] {
    REG_MODEL_SUPPORTED = 2'd0,
    REG_WEIGHT_SCALE    = 2'd1,
    REG_WEIGHT_SHIFT    = 2'd2,
    REG_DEBOUNCE_TICKS  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic                commit;
    logic [CLASS_W-1:0]  active_class;
    logic [CLASS_W-1:0]  query_class;
    logic [WEIGHT_W-1:0] scale;
    logic [SHIFT_W-1:0]  shift;
  } bcast_t;

  typedef struct packed {
    logic [CLASS_W-1:0]  current_class;
    logic                class_committed;
    logic [CONF_W-1:0]   confirm_total;
    logic [WEIGHT_W-1:0] queried_weight;
  } result_t;

endpackage

`default_nettype wire

// ===== design/cdwt_cell.sv =====
// One weight cell: holds the weight of one class and updates it on commit.
// Passes the queried weight along the row; uses cdwt_pkg.
`default_nettype none

module cdwt_cell #(
  parameter int IDX = 0
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           upd,
  input  wire  cdwt_pkg::bcast_t        bc,
  input  wire  [cdwt_pkg::WEIGHT_W-1:0] rd_in,
  output logic [cdwt_pkg::WEIGHT_W-1:0] rd_out
);
  import cdwt_pkg::*;

  logic [WEIGHT_W-1:0] w;
  logic [WEIGHT_W-1:0] w_next;
  logic [WEIGHT_W-1:0] up;
  logic [WEIGHT_W-1:0] round;
  logic [WEIGHT_W:0]   dn;
  logic [WEIGHT_W-1:0] dec;
  logic                active;

  always_comb begin
    active = (int'(bc.active_class) == IDX);
    up     = bc.scale - w;
    round  = ~({WEIGHT_W{1'b1}} << bc.shift);
    dn     = {1'b0, w - bc.scale} + {1'b0, round};
    dec    = w >> bc.shift;
    w_next = w;
    if (upd && bc.commit) begin
      if (active) begin
        if (bc.scale >= w) begin
          w_next = w + (up >> bc.shift);
        end else begin
          w_next = w - WEIGHT_W'(dn >> bc.shift);
        end
      end else if (w != '0) begin
        w_next = w - ((dec != '0) ? dec : 16'd1);
      end
    end
    rd_out = (int'(bc.query_class) == IDX) ? w_next : rd_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w <= '0;
    end else begin
      w <= w_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/cdwt_skid.sv =====
// Two-entry result buffer between the tracker and its consumer.
// Holds result_t from cdwt_pkg.
`default_nettype none

module cdwt_skid (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     push,
  input  wire  cdwt_pkg::result_t din,
  output logic                    space,
  output logic                    head_valid,
  input  wire                     pop,
  output cdwt_pkg::result_t       head
);
  import cdwt_pkg::*;

  logic    v0;
  logic    v1;
  result_t e1;

  assign space      = !v1;
  assign head_valid = v0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (push && !pop) begin
        if (!v0) begin
          head <= din;
          v0   <= 1'b1;
        end else begin
          e1 <= din;
          v1 <= 1'b1;
        end
      end else if (pop && !push) begin
        head <= e1;
        v0   <= v1;
        v1   <= 1'b0;
      end else if (push && pop) begin
        if (v1) begin
          head <= e1;
          e1   <= din;
        end else begin
          head <= din;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/class_debounce_weight_tracker_core.sv =====
// Class debounce weight tracker: debounce control, a row of weight cells, result buffer.
// Each result is registered into the result buffer when its tick request is accepted.
// Throughput: one tick per cycle unless stalled; a commit updates every weight at once.
// Results wait in a two-entry buffer; input stalls only once both entries are full.
// Reset (rst, synchronous): weights, debounce state and buffer clear, registers reload.
`default_nettype none

`include "class_debounce_weight_tracker_core_assert.svh"

module class_debounce_weight_tracker_core #(
  parameter int NUM_CLASSES = 8
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_we,
  input  wire  [1:0]                    cfg_index,
  input  wire  [15:0]                   cfg_data,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire                           mode,
  input  wire                           on_ecore,
  input  wire                           read_failed,
  input  wire  [cdwt_pkg::CLASS_W-1:0]  raw_class,
  input  wire                           siblings_idle,
  input  wire  [cdwt_pkg::CLASS_W-1:0]  query_class,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [cdwt_pkg::CLASS_W-1:0]  current_class,
  output logic                          class_committed,
  output logic [cdwt_pkg::CONF_W-1:0]   confirm_total,
  output logic [cdwt_pkg::WEIGHT_W-1:0] queried_weight
);
  import cdwt_pkg::*;

  logic                model_supported;
  logic [WEIGHT_W-1:0] weight_scale;
  logic [SHIFT_W-1:0]  weight_shift;
  logic [RUN_W-1:0]    debounce_ticks;

  logic [CLASS_W-1:0]  previous_reading;
  logic [RUN_W-1:0]    stable_run;
  logic [CONF_W-1:0]   confirm_count;
  logic [CLASS_W-1:0]  committed_class;

  logic [CLASS_W-1:0]  previous_reading_next;
  logic [RUN_W-1:0]    stable_run_next;
  logic [CONF_W-1:0]   confirm_count_next;
  logic [CLASS_W-1:0]  committed_class_next;

  logic                accept;
  logic                usable;
  logic                commit;
  logic [CLASS_W-1:0]  cls;
  logic [RUN_W-1:0]    run_inc;
  logic [CONF_W-1:0]   conf_base;
  bcast_t              bc;
  result_t             res;
  result_t             head;
  logic [WEIGHT_W-1:0] rd [0:NUM_CLASSES];

  assign accept = in_valid && in_ready;

  always_comb begin
    usable = !on_ecore && !read_failed && model_supported && (raw_class != RAW_INVALID) &&
             ((raw_class == RAW_TRUSTED_LO) || (raw_class == RAW_TRUSTED_HI) || siblings_idle);
    cls     = raw_class + 3'd1;
    run_inc = stable_run + 16'd1;
    commit  = 1'b0;
    conf_base = confirm_count;
    previous_reading_next = previous_reading;
    stable_run_next       = stable_run;
    committed_class_next  = committed_class;
    if (usable) begin
      if (mode) begin
        commit = 1'b1;
        if (committed_class != cls) begin
          conf_base = '0;
        end
      end else begin
        previous_reading_next = cls;
        if (previous_reading != cls) begin
          stable_run_next = 16'd1;
          conf_base       = '0;
        end else if (run_inc < debounce_ticks) begin
          stable_run_next = run_inc;
        end else begin
          commit = 1'b1;
        end
      end
    end
    confirm_count_next = conf_base;
    if (commit) begin
      committed_class_next = cls;
      confirm_count_next   = (conf_base == CONFIRM_MAX) ? conf_base : conf_base + 8'd1;
    end
    bc.commit       = commit;
    bc.active_class = cls;
    bc.query_class  = query_class;
    bc.scale        = weight_scale;
    bc.shift        = weight_shift;
  end

  assign rd[0] = '0;

  for (genvar i = 0; i < NUM_CLASSES; i++) begin : g_cell
    cdwt_cell #(.IDX(i)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .upd    (accept),
      .bc     (bc),
      .rd_in  (rd[i]),
      .rd_out (rd[i+1])
    );
  end

  always_comb begin
    res.current_class   = committed_class_next;
    res.class_committed = commit;
    res.confirm_total   = confirm_count_next;
    res.queried_weight  = rd[NUM_CLASSES];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      model_supported  <= MODEL_SUPPORTED_RST;
      weight_scale     <= WEIGHT_SCALE_RST;
      weight_shift     <= WEIGHT_SHIFT_RST;
      debounce_ticks   <= DEBOUNCE_TICKS_RST;
      previous_reading <= CLASS_NONE;
      stable_run       <= '0;
      confirm_count    <= '0;
      committed_class  <= CLASS_NONE;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_MODEL_SUPPORTED: model_supported <= cfg_data[0];
          REG_WEIGHT_SCALE:    weight_scale    <= cfg_data;
          REG_WEIGHT_SHIFT:    weight_shift    <= cfg_data[SHIFT_W-1:0];
          REG_DEBOUNCE_TICKS:  debounce_ticks  <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        previous_reading <= previous_reading_next;
        stable_run       <= stable_run_next;
        confirm_count    <= confirm_count_next;
        committed_class  <= committed_class_next;
      end
    end
  end

  cdwt_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .din        (res),
    .space      (in_ready),
    .head_valid (out_valid),
    .pop        (out_valid && out_ready),
    .head       (head)
  );

  assign current_class   = head.current_class;
  assign class_committed = head.class_committed;
  assign confirm_total   = head.confirm_total;
  assign queried_weight  = head.queried_weight;

  `CDWT_ASSERT_IMP(a_commit_has_class, clk, rst, accept && commit, committed_class_next != CLASS_NONE)
  `CDWT_ASSERT_IMP(a_commit_counts, clk, rst, accept && commit, confirm_count_next != '0)
  `CDWT_ASSERT_NXT(a_class_holds, clk, rst, !(accept && commit), $stable(committed_class))
  `CDWT_ASSERT_IMP(a_count_needs_class, clk, rst, confirm_count != '0, committed_class != CLASS_NONE)

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for class_debounce_weight_tracker_core: directed tick table, then random runs
// of class readings over several register settings, each result checked against a predictor.
// Depends on cdwt_pkg and the core RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cdwt_pkg::*;

  localparam int NUM_CLASSES = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam bit MODE_DEBOUNCED = 1'b0;
  localparam bit MODE_FINAL     = 1'b1;

  typedef struct packed {
    logic                mode;
    logic                on_ecore;
    logic                read_failed;
    logic [CLASS_W-1:0]  raw_class;
    logic                siblings_idle;
    logic [CLASS_W-1:0]  query_class;
  } tick_t;

  typedef struct {
    bit        mode;
    bit        on_ecore;
    bit        read_failed;
    bit [2:0]  hfi;
    bit        sib;
    bit [2:0]  query;
    bit        typed;
    bit [2:0]  cur;
    bit        comm;
    bit [7:0]  conf;
    bit [15:0] wgt;
  } tick_row_t;

  // Rows up to the mode 1 switch to class seven carry a typed result (default settings).
  tick_row_t tick_table [21] = '{
    '{0, 1, 0, 2, 0, 0, 1, 0, 0, 0, 0},
    '{0, 0, 1, 3, 1, 5, 1, 0, 0, 0, 0},
    '{1, 0, 0, 7, 1, 7, 1, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0},
    '{0, 0, 0, 2, 0, 3, 1, 0, 0, 0, 0},
    '{0, 0, 0, 2, 0, 3, 1, 3, 1, 1, 128},
    '{0, 0, 0, 2, 0, 3, 1, 3, 1, 2, 240},
    '{1, 0, 0, 3, 0, 3, 1, 4, 1, 1, 210},
    '{1, 0, 0, 6, 1, 7, 1, 7, 1, 1, 128},
    '{0, 0, 0, 6, 1, 4, 0, 0, 0, 0, 0},
    '{0, 0, 0, 6, 1, 4, 0, 0, 0, 0, 0},
    '{0, 0, 0, 5, 0, 6, 0, 0, 0, 0, 0},
    '{0, 0, 0, 4, 1, 5, 0, 0, 0, 0, 0},
    '{1, 0, 0, 4, 1, 5, 0, 0, 0, 0, 0},
    '{0, 0, 0, 4, 1, 5, 0, 0, 0, 0, 0},
    '{0, 0, 0, 1, 1, 2, 0, 0, 0, 0, 0},
    '{0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0},
    '{1, 1, 1, 7, 1, 7, 0, 0, 0, 0, 0},
    '{1, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0},
    '{0, 0, 0, 3, 0, 2, 0, 0, 0, 0, 0},
    '{0, 0, 0, 3, 1, 4, 0, 0, 0, 0, 0}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = '0;
  logic [15:0]         cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                mode = 1'b0;
  logic                on_ecore = 1'b0;
  logic                read_failed = 1'b0;
  logic [CLASS_W-1:0]  raw_class = '0;
  logic                siblings_idle = 1'b0;
  logic [CLASS_W-1:0]  query_class = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CLASS_W-1:0]  current_class;
  logic                class_committed;
  logic [CONF_W-1:0]   confirm_total;
  logic [WEIGHT_W-1:0] queried_weight;

  // predictor registers and state
  logic                cfg_supported = MODEL_SUPPORTED_RST;
  logic [WEIGHT_W-1:0] cfg_scale = WEIGHT_SCALE_RST;
  logic [SHIFT_W-1:0]  cfg_shift = WEIGHT_SHIFT_RST;
  logic [RUN_W-1:0]    cfg_debounce = DEBOUNCE_TICKS_RST;
  logic [WEIGHT_W-1:0] weights [NUM_CLASSES];
  logic [CLASS_W-1:0]  prev_reading = '0;
  logic [RUN_W-1:0]    stable_run = '0;
  logic [CONF_W-1:0]   confirm_count = '0;
  logic [CLASS_W-1:0]  committed_cls = CLASS_NONE;

  result_t expected_results [$];
  bit no_gaps = 1'b0;
  int mismatches = 0;
  int ticks_sent = 0;
  int results_seen = 0;
  int commits_seen = 0;
  int settings_used = 1;
  int cycle_count = 0;

  class_debounce_weight_tracker_core #(.NUM_CLASSES(NUM_CLASSES)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .on_ecore(on_ecore), .read_failed(read_failed),
    .raw_class(raw_class), .siblings_idle(siblings_idle), .query_class(query_class),
    .out_valid(out_valid), .out_ready(out_ready),
    .current_class(current_class), .class_committed(class_committed),
    .confirm_total(confirm_total), .queried_weight(queried_weight)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= no_gaps || ($urandom_range(99) >= 14);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             what, results_seen, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (class_committed) commits_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unrequested result", current_class, 0);
      end else begin
        want = expected_results.pop_front();
        if (current_class !== want.current_class)
          report_mismatch("current_class", current_class, want.current_class);
        if (class_committed !== want.class_committed)
          report_mismatch("class_committed", class_committed, want.class_committed);
        if (confirm_total !== want.confirm_total)
          report_mismatch("confirm_total", confirm_total, want.confirm_total);
        if (queried_weight !== want.queried_weight)
          report_mismatch("queried_weight", queried_weight, want.queried_weight);
      end
      results_seen++;
    end
  end

  function automatic void commit_weights(input logic [CLASS_W-1:0] cls);
    int w;
    int dec;
    int scale;
    scale = cfg_scale;
    committed_cls = cls;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      w = weights[i];
      if (i == cls) begin
        if (scale >= w) w = w + ((scale - w) >> cfg_shift);
        else w = w - (((w - scale) + ((1 << cfg_shift) - 1)) >> cfg_shift);
      end else if (w != 0) begin
        dec = w >> cfg_shift;
        w = w - ((dec != 0) ? dec : 1);
      end
      weights[i] = w[WEIGHT_W-1:0];
    end
    if (confirm_count < CONFIRM_MAX) confirm_count++;
  endfunction

  function automatic result_t track_tick(input tick_t t);
    result_t r;
    logic [CLASS_W-1:0] cls;
    logic [RUN_W-1:0] run_next;
    bit trusted;
    r.class_committed = 1'b0;
    trusted = cfg_supported && (t.raw_class == RAW_TRUSTED_LO ||
                                t.raw_class == RAW_TRUSTED_HI || t.siblings_idle);
    if (!t.on_ecore && !t.read_failed && trusted && t.raw_class != RAW_INVALID) begin
      cls = t.raw_class + 3'd1;
      if (t.mode == MODE_FINAL) begin
        if (committed_cls != cls) confirm_count = '0;
        commit_weights(cls);
        r.class_committed = 1'b1;
      end else begin
        run_next = stable_run + 16'd1;
        if (prev_reading != cls) begin
          stable_run = 16'd1;
          confirm_count = '0;
        end else if (run_next < cfg_debounce) begin
          stable_run = run_next;
        end else begin
          commit_weights(cls);
          r.class_committed = 1'b1;
        end
        prev_reading = cls;
      end
    end
    r.current_class = committed_cls;
    r.confirm_total = confirm_count;
    r.queried_weight = (t.query_class < NUM_CLASSES) ? weights[t.query_class] : '0;
    return r;
  endfunction

  task automatic run_tick(input tick_t t, input bit typed, input result_t typed_want);
    result_t predicted;
    if (!no_gaps && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= t.mode;
    on_ecore <= t.on_ecore;
    read_failed <= t.read_failed;
    raw_class <= t.raw_class;
    siblings_idle <= t.siblings_idle;
    query_class <= t.query_class;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = track_tick(t);
    expected_results.push_back(typed ? typed_want : predicted);
    ticks_sent++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_MODEL_SUPPORTED: cfg_supported = value[0];
      REG_WEIGHT_SCALE:    cfg_scale = value;
      REG_WEIGHT_SHIFT:    cfg_shift = value[SHIFT_W-1:0];
      REG_DEBOUNCE_TICKS:  cfg_debounce = value;
      default: ;
    endcase
  endtask

  task automatic program_regs(input bit supported, input int scale, input int shift,
                              input int debounce);
    write_reg(REG_MODEL_SUPPORTED, 16'(supported));
    write_reg(REG_WEIGHT_SCALE, 16'(scale));
    write_reg(REG_WEIGHT_SHIFT, 16'(shift));
    write_reg(REG_DEBOUNCE_TICKS, 16'(debounce));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Runs of one class with random content, plus noise; hold_class pins class 2 for saturation.
  task automatic class_runs(input int count, input bit hold_class);
    tick_t t;
    int sent;
    int run_len;
    logic [CLASS_W-1:0] cls;
    sent = 0;
    cls = RAW_TRUSTED_LO;
    while (sent < count) begin
      if (!hold_class && $urandom_range(99) < 15) begin
        t = tick_t'($bits(tick_t)'($urandom));
        run_tick(t, 1'b0, '0);
        sent++;
      end else begin
        if (!hold_class) cls = CLASS_W'($urandom_range(0, 6));
        run_len = hold_class ? 1 : $urandom_range(1, 6);
        repeat (run_len) begin
          if (hold_class) t.mode = ($urandom_range(99) < 80) ? MODE_FINAL : MODE_DEBOUNCED;
          else t.mode = ($urandom_range(99) < 25) ? MODE_FINAL : MODE_DEBOUNCED;
          t.on_ecore = 1'b0;
          t.read_failed = 1'b0;
          t.raw_class = cls;
          if (cls == RAW_TRUSTED_LO || cls == RAW_TRUSTED_HI)
            t.siblings_idle = 1'($urandom_range(1));
          else t.siblings_idle = ($urandom_range(99) < 90);
          t.query_class = CLASS_W'($urandom_range(7));
          run_tick(t, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    tick_t t;
    result_t want;
    for (int i = 0; i < NUM_CLASSES; i++) weights[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (tick_table[i]) begin
      t = '{tick_table[i].mode, tick_table[i].on_ecore, tick_table[i].read_failed,
            tick_table[i].hfi, tick_table[i].sib, tick_table[i].query};
      want = '{tick_table[i].cur, tick_table[i].comm, tick_table[i].conf, tick_table[i].wgt};
      run_tick(t, tick_table[i].typed, want);
    end
    drain_results();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: program_regs(1'b1, 65535, 0, 1);
        1: program_regs(1'b1, 0, 15, 0);
        2: program_regs(1'b0, 1024, 3, 2);
        3: program_regs(1'b1, 65535, 15, 65535);
        4: program_regs(1'b1, 300, 1, 3);
        default: program_regs($urandom_range(99) < 85, $urandom_range(0, 65535),
                              $urandom_range(0, 15), $urandom_range(1, 6));
      endcase
      no_gaps <= (p == 6);
      class_runs(80, 1'b0);
      drain_results();
    end

    // hold one class long enough to saturate the confirm count
    no_gaps <= 1'b0;
    program_regs(1'b1, $urandom_range(0, 65535), $urandom_range(0, 15), 1);
    class_runs(300, 1'b1);
    drain_results();

    $display("%0d ticks over %0d register settings, %0d results checked, %0d commits",
             ticks_sent, settings_used, results_seen, commits_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
